/* design/fppt_pkg.sv */
// Shared types for the page pool tag store.
// Holds the page key, result, controller command and state encodings.
package fppt_pkg;

    typedef struct packed {
        logic        two_dim;
        logic [15:0] col;
        logic [15:0] row;
        logic [7:0]  obj;
    } page_key_t;

    typedef struct packed {
        logic      evicted;
        page_key_t ev_key;
        logic [5:0] slot;
        logic      hit;
    } pool_result_t;

    typedef struct packed {
        logic capture;
        logic look;
        logic commit;
    } dp_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_DONE = 3'b100
    } ctrl_state_t;

endpackage

/* design/fppt_ctrl.sv */
// Controller for the page pool tag store: sequences capture, lookup and commit.
// Depends on fppt_pkg for the command struct and state encoding.
module fppt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output fppt_pkg::dp_cmd_t cmd
);

    fppt_pkg::ctrl_state_t state_reg;
    fppt_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            fppt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = fppt_pkg::ST_LOOK;
                end
            end
            fppt_pkg::ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = fppt_pkg::ST_DONE;
            end
            fppt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = fppt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fppt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fppt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* design/fppt_dpath.sv */
// Datapath for the page pool tag store: tag registers, valid bits, FIFO pointers.
// Depends on fppt_pkg for key, result and command types.
module fppt_dpath #(
    parameter int POOL_SLOTS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fppt_pkg::dp_cmd_t      cmd,
    input  fppt_pkg::page_key_t    in_key,
    output fppt_pkg::pool_result_t result
);

    localparam int IDX_W  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int FILL_W = $clog2(POOL_SLOTS + 1);

    fppt_pkg::page_key_t    key_reg;
    fppt_pkg::page_key_t    tag_reg [POOL_SLOTS];
    fppt_pkg::page_key_t    evict_key_reg;
    fppt_pkg::pool_result_t result_reg;
    fppt_pkg::pool_result_t result_next;
    logic [POOL_SLOTS-1:0]  valid_reg;
    logic [POOL_SLOTS-1:0]  match_reg;
    logic [POOL_SLOTS-1:0]  match_next;
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;
    logic [IDX_W-1:0]       oldest_reg;
    logic [IDX_W-1:0]       oldest_next;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       target;
    logic                   hit;
    logic                   full;
    logic                   write_en;

    always_comb
    begin
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            match_next[i] = valid_reg[i] && (tag_reg[i] == key_reg);
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            if (match_reg[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign hit  = |match_reg;
    assign full = (fill_reg == FILL_W'(POOL_SLOTS));

    always_comb
    begin
        result_next = '0;
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        target      = hit_idx;
        write_en    = 1'b0;
        if (hit)
        begin
            result_next.hit  = 1'b1;
            result_next.slot = 6'(hit_idx);
        end
        else if (!full)
        begin
            target           = fill_reg[IDX_W-1:0];
            fill_next        = fill_reg + 1'b1;
            write_en         = 1'b1;
            result_next.slot = 6'(target);
        end
        else
        begin
            target              = oldest_reg;
            write_en            = 1'b1;
            result_next.slot    = 6'(target);
            result_next.evicted = 1'b1;
            result_next.ev_key  = evict_key_reg;
            if (oldest_reg == IDX_W'(POOL_SLOTS - 1))
            begin
                oldest_next = '0;
            end
            else
            begin
                oldest_next = oldest_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg.obj     <= in_key.obj;
            key_reg.row     <= in_key.row;
            key_reg.col     <= in_key.two_dim ? in_key.col : 16'h0000;
            key_reg.two_dim <= in_key.two_dim;
        end
        if (cmd.look)
        begin
            match_reg     <= match_next;
            evict_key_reg <= tag_reg[oldest_reg];
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
            if (write_en)
            begin
                tag_reg[target] <= key_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else if (cmd.commit && write_en)
        begin
            valid_reg[target] <= 1'b1;
            fill_reg          <= fill_next;
            oldest_reg        <= oldest_next;
        end
    end

    assign result = result_reg;

endmodule

/* design/fifo_page_pool_tags_unit.sv */
// Page pool tag store with first-in-first-out replacement, top level.
// Each item passes capture, a registered tag compare, then the commit of slot state and result;
// the next item is taken only after that commit, which waits while the output still holds a result.
// A new item is taken while the previous result still waits at the output.
// Reset clears all valid bits, the fill count, the oldest pointer and output valid.
// Depends on fppt_pkg, fppt_ctrl and fppt_dpath.
module fifo_page_pool_tags_unit #(
    parameter int POOL_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // object_id[7:0], page_row[23:8], page_col[39:24]
    input  logic        s_tuser,   // two_dim
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // slot[5:0], evicted_object[13:6], evicted_row[29:14],
                                   // evicted_col[45:30], evicted_two_dim[46], zero[47]
    output logic [1:0]  m_tuser    // hit[0], evicted[1]
);

    fppt_pkg::dp_cmd_t      cmd;
    fppt_pkg::page_key_t    in_key;
    fppt_pkg::pool_result_t result;

    assign in_key.obj     = s_tdata[7:0];
    assign in_key.row     = s_tdata[23:8];
    assign in_key.col     = s_tdata[39:24];
    assign in_key.two_dim = s_tuser;

    fppt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    fppt_dpath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .in_key (in_key),
        .result (result)
    );

    assign m_tdata = {1'b0, result.ev_key.two_dim, result.ev_key.col,
                      result.ev_key.row, result.ev_key.obj, result.slot};
    assign m_tuser = {result.evicted, result.hit};

endmodule

/* tb/tb_top.sv */
// Self-checking bench for fifo_page_pool_tags_unit: hit/miss, slot choice and eviction.
// A built-in tag pool tracks the expected slot contents and FIFO order; no other files.
// Depends on fppt_pkg and the unit RTL only.
module tb_top;

    localparam int POOL = 8;
    localparam int RANDOM_ITEMS = 630;
    localparam int QUIET_LIMIT = 4000;
    localparam int WORK_SET = 12;
    localparam int DUE_DEPTH = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    logic                   pool_valid [POOL];
    fppt_pkg::page_key_t    pool_key [POOL];
    int unsigned            pool_fill = 0;
    int unsigned            pool_oldest = 0;
    fppt_pkg::pool_result_t due_ring [DUE_DEPTH];
    int unsigned            due_head = 0;
    int unsigned            due_tail = 0;
    int unsigned            mismatches = 0;

    fifo_page_pool_tags_unit #(
        .POOL_SLOTS(POOL)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int i = 0; i < POOL; i++)
        begin
            pool_valid[i] = 1'b0;
            pool_key[i] = '0;
        end
    end

    function automatic fppt_pkg::pool_result_t predict_lookup(fppt_pkg::page_key_t req);
        fppt_pkg::pool_result_t res;
        int unsigned            target;
        res = '0;
        if (!req.two_dim)
            req.col = '0;
        for (int i = 0; i < POOL; i++)
        begin
            if (pool_valid[i] && pool_key[i] == req)
            begin
                res.hit = 1'b1;
                res.slot = 6'(i);
                return res;
            end
        end
        if (pool_fill < POOL)
        begin
            target = pool_fill;
            pool_fill++;
        end
        else
        begin
            target = pool_oldest;
            res.evicted = 1'b1;
            res.ev_key = pool_key[target];
            pool_oldest = (target + 1) % POOL;
        end
        pool_valid[target] = 1'b1;
        pool_key[target] = req;
        res.slot = 6'(target);
        return res;
    endfunction

    function automatic fppt_pkg::page_key_t make_page(logic [7:0] obj, logic [15:0] row,
                                                      logic [15:0] col, logic dim);
        fppt_pkg::page_key_t k;
        k.obj = obj;
        k.row = row;
        k.col = col;
        k.two_dim = dim;
        return k;
    endfunction

    function automatic fppt_pkg::page_key_t random_page();
        return make_page(8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic send_page(input fppt_pkg::page_key_t req);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {req.col, req.row, req.obj};
        s_tuser <= req.two_dim;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        due_ring[due_tail % DUE_DEPTH] = predict_lookup(req);
        due_tail++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata <= 40'({$urandom, $urandom});
            s_tuser <= 1'($urandom);
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        fppt_pkg::pool_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_head == due_tail)
                report_mismatch("unexpected item", 64'({m_tuser, m_tdata}), '0);
            else
            begin
                want = due_ring[due_head % DUE_DEPTH];
                due_head++;
                check_field("hit", 64'(m_tuser[0]), 64'(want.hit));
                check_field("evicted", 64'(m_tuser[1]), 64'(want.evicted));
                check_field("slot", 64'(m_tdata[5:0]), 64'(want.slot));
                check_field("evicted_object", 64'(m_tdata[13:6]), 64'(want.ev_key.obj));
                check_field("evicted_row", 64'(m_tdata[29:14]), 64'(want.ev_key.row));
                check_field("evicted_col", 64'(m_tdata[45:30]), 64'(want.ev_key.col));
                check_field("evicted_two_dim", 64'(m_tdata[46]),
                            64'(want.ev_key.two_dim));
                check_field("pad", 64'(m_tdata[47]), 64'(1'b0));
            end
        end
    end

    initial
    begin : sink_pattern
        int mode;
        int span;
        int phase;
        phase = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            repeat (span)
            begin
                @(negedge clk);
                phase++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom);
                    2: m_tready <= (phase % 5) < 3;
                    default: m_tready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[fifo_page_pool_tags_unit] ERROR");
        $finish;
    end

    task automatic test_fill_and_hit;
        send_page(make_page(8'h00, 16'h0000, 16'h0000, 1'b0));
        send_page(make_page(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_page(make_page(8'hFF, 16'hFFFF, 16'h1234, 1'b0));
        send_page(make_page(8'h00, 16'h0000, 16'h0000, 1'b1));
        send_page(make_page(8'hAA, 16'h5555, 16'hAAAA, 1'b1));
        send_page(make_page(8'h55, 16'hAAAA, 16'h5555, 1'b1));
        send_page(make_page(8'h01, 16'h0001, 16'h0001, 1'b0));
        send_page(make_page(8'h80, 16'h8000, 16'h8000, 1'b1));
        send_page(make_page(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_page(make_page(8'h55, 16'hAAAA, 16'h5555, 1'b1));
    endtask

    task automatic test_one_dim_pages;
        send_page(make_page(8'h00, 16'h0000, 16'hFFFF, 1'b0));
        send_page(make_page(8'hFF, 16'hFFFF, 16'h0000, 1'b0));
        send_page(make_page(8'h01, 16'h0001, 16'hBEEF, 1'b0));
        send_page(make_page(8'h01, 16'h0001, 16'h0000, 1'b1));
    endtask

    task automatic test_eviction_order;
        pause_sender(3);
        send_page(make_page(8'h12, 16'h3456, 16'h789A, 1'b1));
        send_page(make_page(8'h34, 16'h0102, 16'h0000, 1'b0));
        send_page(make_page(8'h00, 16'h0000, 16'h0000, 1'b0));
        send_page(make_page(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_page(make_page(8'h80, 16'h8000, 16'h8000, 1'b1));
        send_page(make_page(8'h12, 16'h3456, 16'h789A, 1'b1));
        send_page(make_page(8'h7F, 16'h7FFF, 16'h7FFF, 1'b1));
    endtask

    task automatic test_random_traffic;
        fppt_pkg::page_key_t working [WORK_SET];
        fppt_pkg::page_key_t req;
        int                  sent;
        int                  burst;
        int                  pick;
        int                  idx;
        for (int i = 0; i < WORK_SET; i++)
            working[i] = random_page();
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                pick = $urandom_range(0, 99);
                idx = $urandom_range(0, WORK_SET - 1);
                if (pick < 70)
                begin
                    req = working[idx];
                    if (!req.two_dim)
                        req.col = 16'($urandom);
                end
                else if (pick < 80)
                begin
                    working[idx] = random_page();
                    req = working[idx];
                end
                else if (pick < 90)
                begin
                    req = working[idx];
                    req[$urandom_range(0, 40)] ^= 1'b1;
                end
                else
                    req = random_page();
                send_page(req);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        test_fill_and_hit();
        test_one_dim_pages();
        test_eviction_order();
        test_random_traffic();
        pause_sender(1);
        while (due_head != due_tail)
            @(posedge clk);
        repeat (12)
            @(posedge clk);
        if (mismatches == 0)
            $display("[fifo_page_pool_tags_unit] OK");
        else
            $display("[fifo_page_pool_tags_unit] ERROR");
        $finish;
    end

endmodule
